[rtl/ntw_pkg.sv]
// Shared types and constants for the number-to-word-tokens block.
package ntw_pkg;

  // Width of the binary input value
  localparam int VALUE_BITS  = 31;
  // Three-digit groups: units, thousands, millions, billions
  localparam int GROUPS      = 4;
  localparam int GROUP_BITS  = 12;
  localparam int BCD_BITS    = GROUPS * GROUP_BITS;
  localparam int BCD_DIGITS  = BCD_BITS / 4;
  localparam int CNT_W       = $clog2(VALUE_BITS);
  localparam int GRP_W       = $clog2(GROUPS);

  typedef logic [4:0] word_t;

  // Word codes
  localparam word_t W_ZERO     = 5'd0;
  localparam word_t W_TEN      = 5'd10;
  localparam word_t W_TENS_OFS = 5'd18;
  localparam word_t W_HUNDRED  = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } ntw_state_t;

  // Steps within one three-digit group
  typedef enum logic [4:0] {
    SP_HDIG  = 5'b00001,
    SP_HUND  = 5'b00010,
    SP_TENS  = 5'b00100,
    SP_UNIT  = 5'b01000,
    SP_SCALE = 5'b10000
  } ntw_step_t;

  // Status of the binary-to-BCD converter
  typedef struct packed {
    logic busy;
    logic done;
  } ntw_conv_stat_t;

endpackage

[rtl/ntw_if.sv]
// Valid/ready channel interfaces for the input value and the word stream.
interface ntw_in_if;
  import ntw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ntw_out_if;
  import ntw_pkg::*;
  logic  valid;
  logic  ready;
  word_t word;
  logic  last;
  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

[rtl/number_to_word_tokens.sv]
// Top level: spells a binary integer as English word codes, one per transfer.
//
//   Channel | Dir | Payload              | Handshake
//   in_ch   | in  | value[30:0]          | valid/ready
//   out_ch  | out | word[4:0], last      | valid/ready
//
// An item takes 31 binary-to-BCD shift steps in the converter, then
// 20 sequencer steps (five per digit group, at most one word each), the
// flush state and the idle state in which the next value transfers; an
// output stall holds the sequencer steps and the flush.
// in_ch.ready is high only while the sequencer is idle.
// A word is held back until the next one exists so the final one can carry last.
// Reset (rst_n low, synchronous) returns to idle with no word pending.
module number_to_word_tokens (
  input  logic      clk,
  input  logic      rst_n,
  ntw_in_if.sink    in_ch,
  ntw_out_if.source out_ch
);
  import ntw_pkg::*;

  ntw_state_t          state_r, state_nxt;
  ntw_step_t           step_r, step_nxt;
  logic [GRP_W-1:0]    grp_r, grp_nxt;
  logic [BCD_BITS-1:0] bcd_r, bcd_nxt;
  logic                hold_v_r, hold_v_nxt;
  word_t               hold_w_r, hold_w_nxt;
  logic                out_valid_r, out_valid_nxt;
  word_t               out_word_r, out_word_nxt;
  logic                out_last_r, out_last_nxt;

  ntw_conv_stat_t      conv_stat;
  logic [BCD_BITS-1:0] conv_bcd;
  logic                in_xfer;
  logic                slot_free;
  logic [GROUP_BITS-1:0] grp_digits;
  logic [3:0]          dig_h, dig_t, dig_u;
  logic                cand_v;
  word_t               cand_w;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  ntw_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .value (in_ch.value),
    .stat  (conv_stat),
    .bcd   (conv_bcd)
  );

  // Digits of the current group
  assign grp_digits = bcd_r[grp_r*GROUP_BITS +: GROUP_BITS];
  assign dig_h      = grp_digits[11:8];
  assign dig_t      = grp_digits[7:4];
  assign dig_u      = grp_digits[3:0];

  // Candidate word for the current step
  always_comb begin
    cand_v = 1'b0;
    cand_w = W_ZERO;
    unique case (step_r)
      SP_HDIG: begin
        cand_v = (dig_h != 4'd0);
        cand_w = {1'b0, dig_h};
      end
      SP_HUND: begin
        cand_v = (dig_h != 4'd0);
        cand_w = W_HUNDRED;
      end
      SP_TENS: begin
        if (dig_t == 4'd1) begin
          cand_v = 1'b1;
          cand_w = W_TEN + {1'b0, dig_u};
        end else begin
          cand_v = (dig_t >= 4'd2);
          cand_w = W_TENS_OFS + {1'b0, dig_t};
        end
      end
      SP_UNIT: begin
        cand_v = (dig_t != 4'd1) && (dig_u != 4'd0);
        cand_w = {1'b0, dig_u};
      end
      SP_SCALE: begin
        cand_v = (grp_digits != '0) && (grp_r != '0);
        cand_w = W_THOUSAND + word_t'(grp_r - GRP_W'(1));
      end
      default: begin
        cand_v = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    grp_nxt       = grp_r;
    bcd_nxt       = bcd_r;
    hold_v_nxt    = hold_v_r;
    hold_w_nxt    = hold_w_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          bcd_nxt    = conv_bcd;
          grp_nxt    = GRP_W'(GROUPS - 1);
          step_nxt   = SP_HDIG;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          // push the held word out once a newer one exists
          if (cand_v) begin
            if (hold_v_r) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = hold_w_r;
              out_last_nxt  = 1'b0;
            end
            hold_v_nxt = 1'b1;
            hold_w_nxt = cand_w;
          end
          unique case (step_r)
            SP_HDIG:  step_nxt = SP_HUND;
            SP_HUND:  step_nxt = SP_TENS;
            SP_TENS:  step_nxt = SP_UNIT;
            SP_UNIT:  step_nxt = SP_SCALE;
            SP_SCALE: begin
              step_nxt = SP_HDIG;
              if (grp_r == '0) begin
                state_nxt = ST_FLUSH;
              end else begin
                grp_nxt = grp_r - GRP_W'(1);
              end
            end
            default: step_nxt = SP_HDIG;
          endcase
        end
      end
      ST_FLUSH: begin
        // final word; nothing held means the value was zero
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hold_v_r ? hold_w_r : W_ZERO;
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_HDIG;
      grp_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      grp_r       <= grp_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r      <= bcd_nxt;
    hold_w_r   <= hold_w_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;
  assign out_ch.last  = out_last_r;

  // Checks
  a_conv_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> conv_stat.busy)
    else $error("converter idle while sequencer waits on it");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !conv_stat.busy)
    else $error("converter busy while sequencer idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_CONV))
    else $error("accepted value did not start conversion");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && slot_free) |=> (out_valid_r && out_last_r))
    else $error("flush did not present a last word");

endmodule

[rtl/ntw_bcd_conv.sv]
// Iterative binary-to-BCD converter: one shift-add-3 step per cycle.
module ntw_bcd_conv (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ntw_pkg::VALUE_BITS-1:0]  value,
  output ntw_pkg::ntw_conv_stat_t         stat,
  output logic [ntw_pkg::BCD_BITS-1:0]    bcd
);
  import ntw_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]   adj;
  logic                  last_step;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3
                                                : bcd_r[d*4 +: 4];
    end
  end

  assign last_step = (cnt_r == CNT_W'(VALUE_BITS - 1));

  // Step control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = value;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && last_step;
  assign bcd       = bcd_nxt;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for number_to_word_tokens: random and directed values, word checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntw_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RAND_ITEMS   = 135;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    word_t word;
    logic  last;
  } word_tok_t;

  typedef struct packed {
    value_t value;
    logic   hold;  // wait for every word to drain before sending
  } number_item_t;

  logic clk;
  logic rst_n;

  ntw_in_if  in_bus ();
  ntw_out_if out_bus ();

  number_to_word_tokens uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  number_item_t pending_numbers[$];
  word_tok_t    expected_words[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           queued_count;
  int           sent_count;
  int           error_count;
  int           quiet_cycles;

  // Spell one value into word tokens, most significant group first
  function automatic void spell_number(input value_t v);
    int unsigned grp[4];
    int unsigned g;
    int unsigned h;
    int unsigned t;
    int unsigned u;
    word_t       words[$];
    word_tok_t   tok;
    grp[0] = v % 1000;
    grp[1] = (v / 1000) % 1000;
    grp[2] = (v / 1000000) % 1000;
    grp[3] = v / 1000000000;
    if (v == '0) begin
      words.push_back(W_ZERO);
    end
    for (int i = 3; i >= 0; i--) begin
      g = grp[i];
      if (g != 0) begin
        h = g / 100;
        t = (g / 10) % 10;
        u = g % 10;
        if (h != 0) begin
          words.push_back(word_t'(h));
          words.push_back(W_HUNDRED);
        end
        // teens are one word, other tens take an optional units word
        if (t == 1) begin
          words.push_back(W_TEN + word_t'(u));
        end else begin
          if (t >= 2) words.push_back(W_TENS_OFS + word_t'(t));
          if (u != 0) words.push_back(word_t'(u));
        end
        if (i > 0) words.push_back(W_THOUSAND + word_t'(i - 1));
      end
    end
    foreach (words[k]) begin
      tok.word = words[k];
      tok.last = (k == words.size() - 1);
      expected_words.push_back(tok);
    end
  endfunction

  task automatic queue_number(input value_t v, input logic hold);
    number_item_t item;
    item.value = v;
    item.hold  = hold;
    pending_numbers.push_back(item);
    queued_count++;
  endtask

  // Random values: full-width noise, small values, and group-shaped values
  task automatic queue_random(input int n, input logic hold_first);
    longint unsigned v;
    int unsigned     g;
    int              pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        v = $urandom() & VALUE_MAX;
      end else if (pick < 35) begin
        v = $urandom_range(999);
      end else begin
        v = 0;
        for (int k = 2; k >= 0; k--) begin
          if ($urandom_range(3) == 0) g = 0;
          else g = $urandom_range(9) * 100 + $urandom_range(9) * 10 + $urandom_range(9);
          v = v * 1000 + g;
        end
        v = v + longint'($urandom_range(2)) * 1000000000;
        if (v > VALUE_MAX) v = v - 1000000000;
      end
      queue_number(value_t'(v), (hold_first && i == 0) || $urandom_range(49) == 0);
    end
  endtask

  // Clock and initial input levels
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: present the next pending value once the last one transferred
  always @(posedge clk) begin
    logic         next_valid;
    number_item_t item;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        spell_number(in_bus.value);
        sent_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        next_valid = 1'b0;
        if (pending_numbers.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_numbers[0].hold && expected_words.size() != 0)) begin
          item = pending_numbers.pop_front();
          in_bus.value <= item.value;
          next_valid = 1'b1;
        end
        in_bus.valid <= next_valid;
      end
    end
  end

  // Word monitor: compare each transfer with the oldest expected word
  always @(posedge clk) begin
    word_tok_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual word=%0d last=%0b",
                   $time, out_bus.word, out_bus.last);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_bus.word !== want.word) begin
            $display("%0t: word mismatch: expected %0d, actual %0d",
                     $time, want.word, out_bus.word);
            error_count++;
          end
          if (out_bus.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_bus.last);
            error_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus phases and end of run
  initial begin
    error_count = 0;
    quiet_cycles = 0;
    queued_count = 0;
    sent_count = 0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, teens, tens, hundreds, empty groups, every scale, maximum
    queue_number(0, 1'b0);
    queue_number(1, 1'b0);
    queue_number(9, 1'b0);
    queue_number(10, 1'b0);
    queue_number(13, 1'b0);
    queue_number(19, 1'b0);
    queue_number(20, 1'b0);
    queue_number(21, 1'b0);
    queue_number(99, 1'b0);
    queue_number(100, 1'b0);
    queue_number(105, 1'b0);
    queue_number(118, 1'b0);
    queue_number(999, 1'b0);
    queue_number(1000, 1'b0);
    queue_number(1001, 1'b0);
    queue_number(12345, 1'b0);
    queue_number(1000000, 1'b0);
    queue_number(20000017, 1'b0);
    queue_number(1000000000, 1'b0);
    queue_number(1001001001, 1'b0);
    queue_number(1234567891, 1'b0);
    queue_number(2000000000, 1'b0);
    queue_number(VALUE_MAX, 1'b0);
    queue_number(31'h2AAA_AAAA, 1'b0);
    queue_number(31'h5555_5555, 1'b0);
    queue_random(RAND_ITEMS, 1'b0);
    while (sent_count != queued_count) @(posedge clk);

    send_idle_pct = 47;
    recv_idle_pct = 16;
    queue_random(RAND_ITEMS, 1'b1);
    while (sent_count != queued_count) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RAND_ITEMS, 1'b1);
    while (sent_count != queued_count) @(posedge clk);

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ntw_pkg.sv
rtl/ntw_if.sv
rtl/ntw_bcd_conv.sv
rtl/number_to_word_tokens.sv
tb/sv/testbench.sv
